// ===== rtl/qcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qcs_pkg: shared types and constants for the quadrature counter display
// Widths, register map, reciprocal constants and the segment decoder.
// ---------------------------------------------------------------------------
package qcs_pkg;

    localparam int COUNT_W  = 16;
    localparam int MAG_W    = 17;
    localparam int SHOWN_W  = 14;
    localparam int SCAN_W   = 2;
    localparam int PERIOD_W = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;
    localparam int REGIDX_W = ADDR_W - 2;

    // Register map, in word index units.
    localparam logic [REGIDX_W-1:0] REG_SCAN_PERIOD = 1'b0;

    localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RESET = 16'd1000;

    localparam logic [MAG_W-1:0] SHOW_MOD   = 17'd9999;
    localparam logic [MAG_W-1:0] SHOW_MOD_2 = 17'd19998;
    localparam logic [MAG_W-1:0] SHOW_MOD_3 = 17'd29997;
    localparam logic [MAG_W-1:0] MAG_WRAP   = 17'h10000;

    // Reciprocal multipliers: floor(v * RECIP >> SHIFT) equals the quotient
    // over the whole range each stage sees.
    localparam logic [13:0] RECIP_1000 = 14'd8389;   // shift 23, v < 9999
    localparam logic [15:0] RECIP_100  = 16'd41;     // shift 12, v < 1000
    localparam logic [13:0] RECIP_10   = 14'd103;    // shift 10, v < 100

    localparam logic [7:0] BLANK        = 8'hFF;
    localparam logic [7:0] FIRST_SELECT = 8'h20;

    typedef enum logic [SCAN_W-1:0] {
        POS_THOUSANDS = 2'd0,
        POS_HUNDREDS  = 2'd1,
        POS_TENS      = 2'd2,
        POS_UNITS     = 2'd3
    } qcs_pos_t;

    // Count snapshot handed from the counter to the digit pipeline.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SCAN_W-1:0]  idx;
    } qcs_item_t;

    // Decimal split handed from the digit pipeline to the output stage.
    typedef struct packed {
        logic [3:0]        thousands;
        logic [3:0]        hundreds;
        logic [3:0]        tens;
        logic [6:0]        rem;
        logic [SCAN_W-1:0] idx;
        logic              neg;
    } qcs_split_t;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = BLANK;
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/qcs_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qcs_regs: configuration register port
// Holds the scan period, written and read over the APB-style port.
// ---------------------------------------------------------------------------
module qcs_regs
    import qcs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output logic      [DATA_W-1:0]   prdata,
    output logic                     pready,
    output logic      [PERIOD_W-1:0] scan_period
);

    logic [PERIOD_W-1:0] scan_period_reg;
    logic [REGIDX_W-1:0] reg_index;
    logic                wr_en;

    assign reg_index = paddr[ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite && (reg_index == REG_SCAN_PERIOD);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg <= SCAN_PERIOD_RESET;
        end
        else if (wr_en)
        begin
            scan_period_reg <= pwdata[PERIOD_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_SCAN_PERIOD)
        begin
            prdata = {{(DATA_W-PERIOD_W){1'b0}}, scan_period_reg};
        end
    end

    assign scan_period = scan_period_reg;

endmodule
`default_nettype wire

// ===== rtl/qcs_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qcs_counter: phase sampling, x1 position count and digit scan
// Registers each input beat, detects rising edges of phase A, updates the
// position count and advances the scan position after each dwell.
// ---------------------------------------------------------------------------
module qcs_counter
    import qcs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic                in_valid,
    input  wire logic                phase_a,
    input  wire logic                phase_b,
    input  wire logic [PERIOD_W-1:0] scan_period,
    output logic                     item_valid,
    output qcs_item_t                item
);

    logic                s0_valid_reg;
    logic                s0_a_reg;
    logic                s0_b_reg;
    logic                s1_valid_reg;
    qcs_item_t           s1_item_reg;

    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic                last_a_reg;
    logic [SCAN_W-1:0]   idx_reg;
    logic [SCAN_W-1:0]   idx_next;
    logic [PERIOD_W-1:0] dwell_reg;
    logic [PERIOD_W-1:0] dwell_next;
    logic [PERIOD_W:0]   dwell_sum;
    logic                dwell_done;
    logic                step;

    assign step = advance && s0_valid_reg;

    always_comb
    begin
        count_next = count_reg;
        if (s0_a_reg && !last_a_reg)
        begin
            count_next = s0_b_reg ? (count_reg - 16'd1) : (count_reg + 16'd1);
        end

        // A zero period behaves as one, so the scan moves on every beat.
        dwell_sum  = {1'b0, dwell_reg} + 17'd1;
        dwell_done = (scan_period == '0) || (dwell_sum >= {1'b0, scan_period});
        dwell_next = dwell_done ? '0 : dwell_sum[PERIOD_W-1:0];
        idx_next   = dwell_done ? SCAN_W'(idx_reg + 2'd1) : idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            count_reg    <= '0;
            last_a_reg   <= 1'b0;
            idx_reg      <= '0;
            dwell_reg    <= '0;
        end
        else if (advance)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            if (s0_valid_reg)
            begin
                count_reg  <= count_next;
                last_a_reg <= s0_a_reg;
                idx_reg    <= idx_next;
                dwell_reg  <= dwell_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_a_reg          <= phase_a;
            s0_b_reg          <= phase_b;
            s1_item_reg.count <= count_next;
            s1_item_reg.idx   <= idx_reg;
        end
    end

    assign item_valid = s1_valid_reg;
    assign item       = s1_item_reg;

`ifndef NO_ASSERTIONS
    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(count_reg))
        else $error("position count changed without a beat");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (16'(count_reg - $past(count_reg)) == 16'd0)
              || (16'(count_reg - $past(count_reg)) == 16'd1)
              || (16'(count_reg - $past(count_reg)) == 16'hFFFF))
        else $error("position count moved by more than one");
`endif

endmodule
`default_nettype wire

// ===== rtl/qcs_digits.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// qcs_digits: magnitude, modulo and decimal split pipeline
// Folds the count to abs(count) mod 9999 and splits it into decimal digits
// with reciprocal multiplies, one multiply per stage.
// ---------------------------------------------------------------------------
module qcs_digits
    import qcs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire logic      item_valid,
    input  wire qcs_item_t item,
    output logic           split_valid,
    output qcs_split_t     split
);

    // Valid bits for the modulo stage and split stages s3 to s6; s7 has its own.
    logic [4:0]         valid_reg;
    logic               s7_valid_reg;

    logic [SHOWN_W-1:0] s2_shown_reg;
    logic [SHOWN_W-1:0] s3_shown_reg;
    logic [3:0]         s3_th_reg;
    logic [3:0]         s4_th_reg;
    logic [9:0]         s4_r1_reg;
    logic [3:0]         s5_th_reg;
    logic [9:0]         s5_r1_reg;
    logic [3:0]         s5_hu_reg;
    logic [3:0]         s6_th_reg;
    logic [3:0]         s6_hu_reg;
    logic [6:0]         s6_r2_reg;
    qcs_split_t         s7_reg;

    logic [SCAN_W-1:0]  s2_idx_reg, s3_idx_reg, s4_idx_reg, s5_idx_reg, s6_idx_reg;
    logic               s2_neg_reg, s3_neg_reg, s4_neg_reg, s5_neg_reg, s6_neg_reg;

    logic [MAG_W-1:0]   mag;
    logic [MAG_W-1:0]   folded;
    logic [SHOWN_W-1:0] s2_shown_next;
    logic               s2_neg_next;
    logic [27:0]        th_prod;
    logic [3:0]         s3_th_next;
    logic [9:0]         s4_r1_next;
    logic [15:0]        hu_prod;
    logic [3:0]         s5_hu_next;
    logic [6:0]         s6_r2_next;
    logic [13:0]        tn_prod;
    logic [3:0]         s7_tn_next;

    always_comb
    begin
        // The most negative count folds to 32768.
        mag = item.count[COUNT_W-1] ? (MAG_WRAP - {1'b0, item.count}) : {1'b0, item.count};
        if (mag >= SHOW_MOD_3)
        begin
            folded = mag - SHOW_MOD_3;
        end
        else if (mag >= SHOW_MOD_2)
        begin
            folded = mag - SHOW_MOD_2;
        end
        else if (mag >= SHOW_MOD)
        begin
            folded = mag - SHOW_MOD;
        end
        else
        begin
            folded = mag;
        end
        s2_shown_next = folded[SHOWN_W-1:0];
        s2_neg_next   = (item.count == '0) || item.count[COUNT_W-1];

        th_prod    = 28'(s2_shown_reg) * 28'(RECIP_1000);
        s3_th_next = th_prod[26:23];

        s4_r1_next = 10'(s3_shown_reg - 14'(s3_th_reg) * 14'd1000);

        hu_prod    = 16'(s4_r1_reg) * RECIP_100;
        s5_hu_next = hu_prod[15:12];

        s6_r2_next = 7'(s5_r1_reg - 10'(s5_hu_reg) * 10'd100);

        tn_prod    = 14'(s6_r2_reg) * RECIP_10;
        s7_tn_next = tn_prod[13:10];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            s7_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg    <= {valid_reg[3:0], item_valid};
            s7_valid_reg <= valid_reg[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_shown_reg <= s2_shown_next;
            s2_idx_reg   <= item.idx;
            s2_neg_reg   <= s2_neg_next;

            s3_shown_reg <= s2_shown_reg;
            s3_th_reg    <= s3_th_next;
            s3_idx_reg   <= s2_idx_reg;
            s3_neg_reg   <= s2_neg_reg;

            s4_th_reg    <= s3_th_reg;
            s4_r1_reg    <= s4_r1_next;
            s4_idx_reg   <= s3_idx_reg;
            s4_neg_reg   <= s3_neg_reg;

            s5_th_reg    <= s4_th_reg;
            s5_r1_reg    <= s4_r1_reg;
            s5_hu_reg    <= s5_hu_next;
            s5_idx_reg   <= s4_idx_reg;
            s5_neg_reg   <= s4_neg_reg;

            s6_th_reg    <= s5_th_reg;
            s6_hu_reg    <= s5_hu_reg;
            s6_r2_reg    <= s6_r2_next;
            s6_idx_reg   <= s5_idx_reg;
            s6_neg_reg   <= s5_neg_reg;

            s7_reg.thousands <= s6_th_reg;
            s7_reg.hundreds  <= s6_hu_reg;
            s7_reg.tens      <= s7_tn_next;
            s7_reg.rem       <= s6_r2_reg;
            s7_reg.idx       <= s6_idx_reg;
            s7_reg.neg       <= s6_neg_reg;
        end
    end

    assign split_valid = s7_valid_reg;
    assign split       = s7_reg;

`ifndef NO_ASSERTIONS
    a_thousands_digit: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> (s3_th_reg <= 4'd9) && (s3_shown_reg < 14'd9999))
        else $error("thousands quotient out of range");

    a_hundreds_digit: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> (s5_hu_reg <= 4'd9) && (s5_r1_reg < 10'd1000))
        else $error("hundreds quotient out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/quadrature_count_sevenseg_display_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted beat passes the sample, item, modulo, split and output registers.
// Throughput: one input beat per cycle, one result beat per input beat; the
// whole pipeline moves whenever the output register is empty or being taken.
// The depth comes from the modulo stage and one reciprocal multiply per stage.
// Reset (rst_n low, asynchronous) clears the count, scan and all valid bits
// and loads a scan period of 1000; the block takes beats right after reset.
// ---------------------------------------------------------------------------
// quadrature_count_sevenseg_display_top: encoder counter with 7-seg drive
// Counts x1 quadrature edges and drives a four-digit multiplexed display.
// ---------------------------------------------------------------------------
module quadrature_count_sevenseg_display_top
    import qcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              phase_a,
    input  wire logic              phase_b,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             segments,
    output logic [7:0]             digit_enable,
    output logic                   negative_led,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    logic                advance;
    logic [PERIOD_W-1:0] scan_period;
    logic                item_valid;
    qcs_item_t           item;
    logic                split_valid;
    qcs_split_t          split;

    logic                out_valid_reg;
    logic [7:0]          segments_reg;
    logic [7:0]          digit_enable_reg;
    logic                negative_led_reg;

    logic [3:0]          units;
    logic [3:0]          digit;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    qcs_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .scan_period (scan_period)
    );

    qcs_counter u_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (in_valid),
        .phase_a     (phase_a),
        .phase_b     (phase_b),
        .scan_period (scan_period),
        .item_valid  (item_valid),
        .item        (item)
    );

    qcs_digits u_digits (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item_valid  (item_valid),
        .item        (item),
        .split_valid (split_valid),
        .split       (split)
    );

    always_comb
    begin
        units = 4'(split.rem - 7'(split.tens) * 7'd10);
        unique case (qcs_pos_t'(split.idx))
            POS_THOUSANDS: digit = split.thousands;
            POS_HUNDREDS:  digit = split.hundreds;
            POS_TENS:      digit = split.tens;
            POS_UNITS:     digit = units;
            default:       digit = units;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= split_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            segments_reg     <= seg_of(digit);
            digit_enable_reg <= BLANK & ~(FIRST_SELECT >> split.idx);
            negative_led_reg <= split.neg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign segments     = segments_reg;
    assign digit_enable = digit_enable_reg;
    assign negative_led = negative_led_reg;

`ifndef NO_ASSERTIONS
    a_one_digit_lit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones(~digit_enable) == 1)
                   && (digit_enable[7:6] == 2'b11) && (digit_enable[1:0] == 2'b11))
        else $error("digit select does not light exactly one of the four digits");
`endif

endmodule
`default_nettype wire

// ===== tb/quadrature_count_sevenseg_display_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_count_sevenseg_display_top_test: encoder counter display bench
// Drives sampled encoder phases through a valid/ready channel and programs
// the scan period over the register port. A behavioral model of the counter
// and digit scan predicts every display beat, and each beat taken from the
// result channel is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module quadrature_count_sevenseg_display_top_test;
    import qcs_pkg::*;

    localparam int IDLE_PCT       = 18;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 100;
    localparam int SHOWN_MODULUS  = 9999;
    localparam int SWEEP_EDGES    = 30;

    localparam logic [7:0] SEG_PATTERN [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    // Quadrature cycle for forward motion, written as {A, B}.
    localparam logic [1:0] QUAD_STEP [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

    typedef struct packed {
        logic [7:0] segments;
        logic [7:0] digit_enable;
        logic       negative_led;
    } drive_t;

    typedef struct packed {
        bit     a;
        bit     b;
        bit     typed;
        drive_t drive;
    } step_row_t;

    // Rows with typed values sit at reset, at the first up and down edges and
    // at the zero crossing; the scan stays on the thousands digit throughout.
    localparam step_row_t DIRECTED_ROWS [18] = '{
        '{1'b0, 1'b0, 1'b1, '{8'hC0, 8'hDF, 1'b1}},
        '{1'b1, 1'b0, 1'b1, '{8'hC0, 8'hDF, 1'b0}},
        '{1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 1'b1, 1'b0, '0},
        '{1'b1, 1'b1, 1'b1, '{8'hC0, 8'hDF, 1'b1}},
        '{1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b1, 1'b1, '{8'hC0, 8'hDF, 1'b1}},
        '{1'b0, 1'b1, 1'b0, '0},
        '{1'b1, 1'b1, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b1, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0},
        '{1'b0, 1'b0, 1'b0, '0},
        '{1'b1, 1'b0, 1'b0, '0}
    };

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic              phase_a      = 1'b0;
    logic              phase_b      = 1'b0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [7:0]        segments;
    logic [7:0]        digit_enable;
    logic              negative_led;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Predicted block state.
    logic signed [COUNT_W-1:0] enc_count;
    logic                      last_a;
    qcs_pos_t                  scan_pos;
    logic [PERIOD_W-1:0]       dwell;
    logic [PERIOD_W-1:0]       scan_period;

    drive_t display_queue [$];
    int     errors       = 0;
    int     reports      = 0;
    int     quiet_cycles = 0;
    bit     calm         = 1'b0;

    always #2 clk = ~clk;

    quadrature_count_sevenseg_display_top DUT (.*);

    // One tick of the counter and scan; returns the display drive it shows.
    function automatic drive_t advance_encoder(input bit a, input bit b);
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] shown;
        logic [3:0]       digit;
        logic [PERIOD_W:0] span;
        logic [1:0]       next_pos;
        drive_t           d;
        if (a && !last_a)
            enc_count = b ? enc_count - 16'sd1 : enc_count + 16'sd1;
        last_a = a;
        if (enc_count < 0)
            mag = MAG_W'(17'h10000 - {1'b0, enc_count});
        else
            mag = {1'b0, enc_count};
        shown = MAG_W'(mag % SHOWN_MODULUS);
        case (scan_pos)
            POS_THOUSANDS: digit = 4'((shown / 1000) % 10);
            POS_HUNDREDS:  digit = 4'((shown / 100) % 10);
            POS_TENS:      digit = 4'((shown / 10) % 10);
            default:       digit = 4'(shown % 10);
        endcase
        d.segments     = SEG_PATTERN[digit];
        d.digit_enable = BLANK & ~(FIRST_SELECT >> scan_pos);
        d.negative_led = (enc_count <= 0);
        // A zero period behaves as one.
        span = (scan_period == '0) ? 17'd1 : {1'b0, scan_period};
        if ({1'b0, dwell} + 17'd1 >= span) begin
            dwell    = '0;
            next_pos = scan_pos + 2'd1;
            scan_pos = qcs_pos_t'(next_pos);
        end else begin
            dwell = dwell + 1'b1;
        end
        return d;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(input bit a, input bit b, input bit typed = 1'b0,
                             input drive_t typed_drive = '0);
        drive_t d;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        phase_a  <= a;
        phase_b  <= b;
        do @(posedge clk); while (!in_ready);
        d = advance_encoder(a, b);
        display_queue.push_back(typed ? typed_drive : d);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (display_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_scan_period(input logic [PERIOD_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_SCAN_PERIOD, 2'b00};
        pwdata  <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        scan_period = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly clean quadrature bursts in either direction, with some noise
    // beats that hold a level, glitch one phase or jump at random.
    task automatic run_encoder_phase(input int beats);
        int         sent;
        int         burst;
        bit         reverse;
        logic [1:0] q;
        sent = 0;
        q    = 2'd0;
        while (sent < beats) begin
            if ($urandom_range(99) < 15) begin
                send_beat(1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end else begin
                reverse = 1'($urandom_range(1));
                burst   = $urandom_range(24, 4);
                repeat (burst) begin
                    q = reverse ? q - 2'd1 : q + 2'd1;
                    send_beat(QUAD_STEP[q][1], QUAD_STEP[q][0]);
                    sent++;
                end
            end
        end
    endtask

    // Steps the count down through zero into negative values, one down edge
    // for every pair of beats.
    task automatic sweep_down(input int edges);
        repeat (edges) begin
            send_beat(1'b0, 1'($urandom_range(1)));
            send_beat(1'b1, 1'b1);
        end
    endtask

    task automatic flag_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        errors++;
        if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t ns: %s expected %02h, got %02h", $time, field, want, got);
        end
    endtask

    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk) begin
        drive_t want;
        if (rst_n && out_valid && out_ready) begin
            if (display_queue.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("%0t ns: result with none expected, got %02h %02h %0b",
                             $time, segments, digit_enable, negative_led);
                end
            end else begin
                want = display_queue.pop_front();
                if (segments !== want.segments)
                    flag_mismatch("segments", want.segments, segments);
                if (digit_enable !== want.digit_enable)
                    flag_mismatch("digit_enable", want.digit_enable, digit_enable);
                if (negative_led !== want.negative_led)
                    flag_mismatch("negative_led", 8'(want.negative_led), 8'(negative_led));
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        enc_count   = '0;
        last_a      = 1'b0;
        scan_pos    = POS_THOUSANDS;
        dwell       = '0;
        scan_period = SCAN_PERIOD_RESET;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[i])
            send_beat(DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].drive);

        // Zero period while the dwell is well past one: the scan must move
        // on at the very next tick.
        write_scan_period(16'd0);
        sweep_down(SWEEP_EDGES);

        write_scan_period(16'hFFFF);
        run_encoder_phase(150);
        write_scan_period(16'd7);
        run_encoder_phase(200);
        write_scan_period(16'd1);
        calm = 1'b1;
        run_encoder_phase(250);
        calm = 1'b0;
        write_scan_period(16'($urandom_range(12, 2)));
        run_encoder_phase(100);
        wait_drained();
        run_encoder_phase(100);
        write_scan_period(16'($urandom_range(65535, 1)));
        run_encoder_phase(150);
        write_scan_period(16'd3);
        run_encoder_phase(250);

        wait_drained();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
